/* sv/sda_pkg.sv */
// Shared types, codes and the power-of-ten table for the scaled decimal ALU.
package sda_pkg;

    // Largest decimal precision the unit accepts
    localparam int unsigned MAX_PRECISION = 19;
    localparam logic [4:0]  PREC_MAX      = 5'(MAX_PRECISION);

    // Operation codes
    localparam logic [2:0] MODE_ADD  = 3'd0;
    localparam logic [2:0] MODE_SUB  = 3'd1;
    localparam logic [2:0] MODE_MUL  = 3'd2;
    localparam logic [2:0] MODE_DIV  = 3'd3;
    localparam logic [2:0] MODE_CONV = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_PRECISION = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_UNDERFLOW = 3'd3;
    localparam logic [2:0] ST_DIVZERO   = 3'd4;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_DIV
    } t_state;

    // Divider status back to the sequencer
    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [63:0] quo;
    } t_div_res;

    // Ten to the power p; anything from 19 up saturates at 10^19
    function automatic logic [63:0] pow10(input logic [4:0] p);
        logic [63:0] r;
        case (p)
            5'd0:    r = 64'd1;
            5'd1:    r = 64'd10;
            5'd2:    r = 64'd100;
            5'd3:    r = 64'd1000;
            5'd4:    r = 64'd10000;
            5'd5:    r = 64'd100000;
            5'd6:    r = 64'd1000000;
            5'd7:    r = 64'd10000000;
            5'd8:    r = 64'd100000000;
            5'd9:    r = 64'd1000000000;
            5'd10:   r = 64'd10000000000;
            5'd11:   r = 64'd100000000000;
            5'd12:   r = 64'd1000000000000;
            5'd13:   r = 64'd10000000000000;
            5'd14:   r = 64'd100000000000000;
            5'd15:   r = 64'd1000000000000000;
            5'd16:   r = 64'd10000000000000000;
            5'd17:   r = 64'd100000000000000000;
            5'd18:   r = 64'd1000000000000000000;
            default: r = 64'd10000000000000000000;
        endcase
        return r;
    endfunction

endpackage

/* sv/sda_mul.sv */
// 64x64 to 128-bit multiplier built from one 32x32 unit over four partial products.
module sda_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_go,
    input  logic [63:0]  i_x,
    input  logic [63:0]  i_y,
    output logic         o_done,
    output logic [127:0] o_prod
);

    logic [63:0]  r_x;
    logic [63:0]  r_y;
    logic [1:0]   r_idx;
    logic         r_run;
    logic [63:0]  r_pp;
    logic [1:0]   r_pp_idx;
    logic         r_pp_vld;
    logic         r_done;
    logic [127:0] r_acc;
    logic [31:0]  w_opx;
    logic [31:0]  w_opy;
    logic [127:0] w_addend;

    // Operand halves for the current partial product
    always_comb begin
        case (r_idx)
            2'd0:    begin w_opx = r_x[31:0];  w_opy = r_y[31:0];  end
            2'd1:    begin w_opx = r_x[31:0];  w_opy = r_y[63:32]; end
            2'd2:    begin w_opx = r_x[63:32]; w_opy = r_y[31:0];  end
            default: begin w_opx = r_x[63:32]; w_opy = r_y[63:32]; end
        endcase
    end

    // Weight of the registered partial product
    always_comb begin
        case (r_pp_idx) inside
            2'd0:       w_addend = {64'd0, r_pp};
            2'd1, 2'd2: w_addend = {32'd0, r_pp, 32'd0};
            default:    w_addend = {r_pp, 64'd0};
        endcase
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_pp_vld <= 1'b0;
            r_done   <= 1'b0;
            r_idx    <= 2'd0;
        end else begin
            r_pp_vld <= r_run;
            r_done   <= r_pp_vld && (r_pp_idx == 2'd3);
            if (i_go) begin
                r_run <= 1'b1;
                r_idx <= 2'd0;
            end else if (r_run) begin
                r_idx <= r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    // Datapath: multiply into a register, then accumulate in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_acc <= '0;
        end else if (r_pp_vld) begin
            r_acc <= r_acc + w_addend;
        end
        if (r_run) begin
            r_pp     <= w_opx * w_opy;
            r_pp_idx <= r_idx;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

/* sv/sda_div.sv */
// Radix-2 restoring divider: 128-bit dividend by 64-bit divisor, one quotient bit a cycle.
module sda_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [63:0]      i_hi,
    input  logic [63:0]      i_lo,
    input  logic [63:0]      i_d,
    output sda_pkg::t_div_res o_res
);

    logic [63:0] r_rem;
    logic [63:0] r_lo;
    logic [63:0] r_d;
    logic [5:0]  r_cnt;
    logic        r_run;
    logic        r_done;
    logic        r_ovf;
    logic [65:0] w_trial;
    logic        w_take;
    logic        w_ovf;

    // Quotient would not fit in 64 bits
    assign w_ovf = (i_hi >= i_d);

    // Shift in the next dividend bit and try the subtraction
    assign w_trial = {1'b0, r_rem, r_lo[63]} - {2'b00, r_d};
    assign w_take  = !w_trial[65];

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            // Done straight away on overflow, else after the last step
            r_done <= i_go ? w_ovf : (r_run && (r_cnt == 6'd63));
            if (i_go) begin
                r_run <= !w_ovf;
                r_cnt <= 6'd0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    // Datapath; quotient bits shift in behind the dividend
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= i_hi;
            r_lo  <= i_lo;
            r_d   <= i_d;
            r_ovf <= w_ovf;
        end else if (r_run) begin
            r_rem <= w_take ? w_trial[63:0] : {r_rem[62:0], r_lo[63]};
            r_lo  <= {r_lo[62:0], w_take};
        end
    end

    assign o_res.done = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.quo  = r_lo;

endmodule

/* sv/scaled_decimal_alu_core.sv */
// Top level of the scaled decimal ALU: input capture, sequencer and result register.
//
// Usage
//   A word is taken at a rising edge where start is high and busy is low;
//   i_mode, i_operand_a/b and i_precision_a/b are sampled at that edge.
//   busy stays high until the result is produced. Each word yields one
//   result: o_result_value, o_result_precision and o_status are valid for
//   exactly one cycle while o_strobe is high. The receiver cannot stall.
// Operation paths (accept edge to strobe cycle)
//   Add, subtract, precision errors, divide by zero: finished in decode.
//   Convert upwards: multiply (four 32x32 partial products).
//   Convert downwards: 64-step restoring divide.
//   Multiply and divide: multiply, then 64-step divide;
//   quotient overflow is found before the divide loop.
//   The shared 1-bit-per-cycle divider sets the throughput of multiply, divide
//   and downward convert; busy drops in the strobe cycle, so a new word may be taken in that same cycle.
// Reset
//   i_rst_n is synchronous, active low; it returns the sequencer to idle
//   and clears the strobe. Operand and result registers are not reset.
module scaled_decimal_alu_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_mode,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    input  logic [4:0]  i_precision_a,
    input  logic [4:0]  i_precision_b,
    output logic        o_strobe,
    output logic [63:0] o_result_value,
    output logic [4:0]  o_result_precision,
    output logic [2:0]  o_status
);

    sda_pkg::t_state   r_state;
    sda_pkg::t_state   n_state;
    logic [2:0]        r_mode;
    logic [63:0]       r_a;
    logic [63:0]       r_b;
    logic [4:0]        r_pa;
    logic [4:0]        r_pb;
    logic              r_strobe;
    logic [63:0]       r_value;
    logic [4:0]        r_prec;
    logic [2:0]        r_status;

    logic              w_accept;
    logic              w_prec_err;
    logic [64:0]       w_sum;
    logic              w_conv_up;
    logic [4:0]        w_rp;
    logic              w_mul_go;
    logic [63:0]       w_mul_x;
    logic [63:0]       w_mul_y;
    logic              w_mul_done;
    logic [127:0]      w_prod;
    logic              w_div_go;
    logic [63:0]       w_div_hi;
    logic [63:0]       w_div_lo;
    logic [63:0]       w_div_d;
    sda_pkg::t_div_res w_div;
    logic              w_fin;
    logic [63:0]       w_fin_value;
    logic [2:0]        w_fin_status;

    assign w_accept = start && (r_state == sda_pkg::S_IDLE);

    // Operand checks
    assign w_prec_err = (r_mode > sda_pkg::MODE_CONV) || (r_pa > sda_pkg::PREC_MAX)
                     || (r_pb > sda_pkg::PREC_MAX)
                     || ((r_mode != sda_pkg::MODE_CONV) && (r_pa != r_pb));
    assign w_sum      = {1'b0, r_a} + {1'b0, r_b};
    assign w_conv_up  = (r_pb >= r_pa);
    assign w_rp       = (r_mode == sda_pkg::MODE_CONV) ? r_pb : r_pa;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sda_pkg::S_IDLE: begin
                if (start) n_state = sda_pkg::S_DECODE;
            end
            sda_pkg::S_DECODE: begin
                if (w_prec_err) begin
                    n_state = sda_pkg::S_IDLE;
                end else if (r_mode == sda_pkg::MODE_MUL) begin
                    n_state = sda_pkg::S_MUL;
                end else if (r_mode == sda_pkg::MODE_DIV) begin
                    n_state = (r_b == 64'd0) ? sda_pkg::S_IDLE : sda_pkg::S_MUL;
                end else if (r_mode == sda_pkg::MODE_CONV) begin
                    n_state = w_conv_up ? sda_pkg::S_MUL : sda_pkg::S_DIV;
                end else begin
                    n_state = sda_pkg::S_IDLE;
                end
            end
            sda_pkg::S_MUL: begin
                if (w_mul_done) begin
                    n_state = (r_mode == sda_pkg::MODE_CONV) ? sda_pkg::S_IDLE
                                                             : sda_pkg::S_DIV;
                end
            end
            sda_pkg::S_DIV: begin
                if (w_div.done) n_state = sda_pkg::S_IDLE;
            end
            default: n_state = sda_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: unit starts, operands and finishing result
    always_comb begin
        w_mul_go     = 1'b0;
        w_mul_x      = r_a;
        w_mul_y      = r_b;
        w_div_go     = 1'b0;
        w_div_hi     = w_prod[127:64];
        w_div_lo     = w_prod[63:0];
        w_div_d      = r_b;
        w_fin        = 1'b0;
        w_fin_value  = 64'd0;
        w_fin_status = sda_pkg::ST_OK;
        unique case (r_state)
            sda_pkg::S_IDLE: begin
            end
            sda_pkg::S_DECODE: begin
                if (w_prec_err) begin
                    w_fin        = 1'b1;
                    w_fin_status = sda_pkg::ST_PRECISION;
                end else if (r_mode == sda_pkg::MODE_ADD) begin
                    w_fin = 1'b1;
                    if (w_sum[64]) w_fin_status = sda_pkg::ST_OVERFLOW;
                    else           w_fin_value  = w_sum[63:0];
                end else if (r_mode == sda_pkg::MODE_SUB) begin
                    w_fin = 1'b1;
                    if (r_b > r_a) w_fin_status = sda_pkg::ST_UNDERFLOW;
                    else           w_fin_value  = r_a - r_b;
                end else if (r_mode == sda_pkg::MODE_MUL) begin
                    w_mul_go = 1'b1;
                end else if (r_mode == sda_pkg::MODE_DIV) begin
                    if (r_b == 64'd0) begin
                        w_fin        = 1'b1;
                        w_fin_status = sda_pkg::ST_DIVZERO;
                    end else begin
                        w_mul_go = 1'b1;
                        w_mul_y  = sda_pkg::pow10(r_pa);
                    end
                end else if (w_conv_up) begin
                    w_mul_go = 1'b1;
                    w_mul_y  = sda_pkg::pow10(r_pb - r_pa);
                end else begin
                    // Scale down: divide a by 10^(pa-pb) with a zero high word
                    w_div_go = 1'b1;
                    w_div_hi = 64'd0;
                    w_div_lo = r_a;
                    w_div_d  = sda_pkg::pow10(r_pa - r_pb);
                end
            end
            sda_pkg::S_MUL: begin
                if (w_mul_done) begin
                    if (r_mode == sda_pkg::MODE_CONV) begin
                        w_fin = 1'b1;
                        if (w_prod[127:64] != 64'd0) w_fin_status = sda_pkg::ST_OVERFLOW;
                        else                         w_fin_value  = w_prod[63:0];
                    end else begin
                        w_div_go = 1'b1;
                        if (r_mode == sda_pkg::MODE_MUL) w_div_d = sda_pkg::pow10(r_pa);
                    end
                end
            end
            sda_pkg::S_DIV: begin
                if (w_div.done) begin
                    w_fin = 1'b1;
                    if (w_div.ovf) w_fin_status = sda_pkg::ST_OVERFLOW;
                    else           w_fin_value  = w_div.quo;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sda_pkg::S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= w_fin;
        end
    end

    // Input word capture and result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_mode;
            r_a    <= i_operand_a;
            r_b    <= i_operand_b;
            r_pa   <= i_precision_a;
            r_pb   <= i_precision_b;
        end
        if (w_fin) begin
            r_value  <= w_fin_value;
            r_status <= w_fin_status;
            r_prec   <= (w_rp > sda_pkg::PREC_MAX) ? 5'd0 : w_rp;
        end
    end

    sda_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_mul_go),
        .i_x     (w_mul_x),
        .i_y     (w_mul_y),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    sda_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_div_go),
        .i_hi    (w_div_hi),
        .i_lo    (w_div_lo),
        .i_d     (w_div_d),
        .o_res   (w_div)
    );

    assign busy               = (r_state != sda_pkg::S_IDLE);
    assign o_strobe           = r_strobe;
    assign o_result_value     = r_value;
    assign o_result_precision = r_prec;
    assign o_status           = r_status;

`ifndef SYNTHESIS
    // A failed operation never reports a value
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != sda_pkg::ST_OK)) |-> (o_result_value == 64'd0))
        else $error("nonzero value with error status");

    // A result only follows a cycle of work
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a word in flight");

    // An accepted word makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start the sequencer");

    // Reported precision stays within range
    a_prec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result_precision <= sda_pkg::PREC_MAX))
        else $error("result precision out of range");
`endif

endmodule

/* test/sda_checker.sv */
`timescale 1ns / 100ps
// Result checker for the scaled decimal ALU: predicts each accepted word and compares results.
module sda_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [2:0]  i_mode,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    input  logic [4:0]  i_precision_a,
    input  logic [4:0]  i_precision_b,
    input  logic        i_strobe,
    input  logic [63:0] i_result_value,
    input  logic [4:0]  i_result_precision,
    input  logic [2:0]  i_status,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results,
    output int          o_flagged
);

    // One predicted result word
    typedef struct packed {
        logic [63:0] value;
        logic [4:0]  precision;
        logic [2:0]  status;
    } t_sda_result;

    t_sda_result scaled_results_q[$];

    // 10^p for p up to 19
    function automatic logic [63:0] ten_pow(input logic [4:0] p);
        logic [63:0] acc;
        acc = 64'd1;
        for (int k = 0; k < p && k < 19; k++)
            acc = acc * 64'd10;
        return acc;
    endfunction

    // Scaled arithmetic done at full 128-bit width
    function automatic t_sda_result scaled_outcome(input logic [2:0]  m,
                                                   input logic [63:0] a,
                                                   input logic [63:0] b,
                                                   input logic [4:0]  pa,
                                                   input logic [4:0]  pb);
        t_sda_result r;
        logic [127:0] wide;
        logic [4:0]   rp;
        r.value  = '0;
        r.status = sda_pkg::ST_OK;
        rp = (m == sda_pkg::MODE_CONV) ? pb : pa;
        if (m > sda_pkg::MODE_CONV || pa > sda_pkg::PREC_MAX || pb > sda_pkg::PREC_MAX ||
            (m != sda_pkg::MODE_CONV && pa != pb)) begin
            r.status = sda_pkg::ST_PRECISION;
        end else begin
            case (m)
                sda_pkg::MODE_ADD: begin
                    wide = {64'd0, a} + {64'd0, b};
                    if (wide[64]) r.status = sda_pkg::ST_OVERFLOW;
                    else r.value = wide[63:0];
                end
                sda_pkg::MODE_SUB: begin
                    if (b > a) r.status = sda_pkg::ST_UNDERFLOW;
                    else r.value = a - b;
                end
                sda_pkg::MODE_MUL: begin
                    wide = ({64'd0, a} * {64'd0, b}) / {64'd0, ten_pow(pa)};
                    if (wide[127:64] != '0) r.status = sda_pkg::ST_OVERFLOW;
                    else r.value = wide[63:0];
                end
                sda_pkg::MODE_DIV: begin
                    if (b == '0) begin
                        r.status = sda_pkg::ST_DIVZERO;
                    end else begin
                        wide = ({64'd0, a} * {64'd0, ten_pow(pa)}) / {64'd0, b};
                        if (wide[127:64] != '0) r.status = sda_pkg::ST_OVERFLOW;
                        else r.value = wide[63:0];
                    end
                end
                default: begin
                    // precision conversion: scale up or truncate down
                    if (pb >= pa) begin
                        wide = {64'd0, a} * {64'd0, ten_pow(pb - pa)};
                        if (wide[127:64] != '0) r.status = sda_pkg::ST_OVERFLOW;
                        else r.value = wide[63:0];
                    end else begin
                        r.value = a / ten_pow(pa - pb);
                    end
                end
            endcase
        end
        if (r.status != sda_pkg::ST_OK) r.value = '0;
        r.precision = (rp > sda_pkg::PREC_MAX) ? 5'd0 : rp;
        return r;
    endfunction

    // Result compare first, then capture of a newly accepted word
    always @(posedge i_clk) begin : scoreboard
        t_sda_result want;
        int bad;
        int seen;
        int flagged;
        bad     = 0;
        seen    = 0;
        flagged = 0;
        if (!i_rst_n) begin
            scaled_results_q.delete();
        end else begin
            if (i_strobe) begin
                if (scaled_results_q.size() == 0) begin
                    $error("result word with no prediction waiting: value %h", i_result_value);
                    bad++;
                end else begin
                    want = scaled_results_q.pop_front();
                    seen = 1;
                    if (i_status != sda_pkg::ST_OK) flagged = 1;
                    if (i_result_value !== want.value) begin
                        $error("result_value mismatch: expected %h, got %h",
                               want.value, i_result_value);
                        bad++;
                    end
                    if (i_result_precision !== want.precision) begin
                        $error("result_precision mismatch: expected %0d, got %0d",
                               want.precision, i_result_precision);
                        bad++;
                    end
                    if (i_status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, i_status);
                        bad++;
                    end
                end
            end
            if (i_start && !i_busy)
                scaled_results_q.push_back(scaled_outcome(i_mode, i_operand_a, i_operand_b,
                                                          i_precision_a, i_precision_b));
        end
        o_fail_count <= o_fail_count + bad;
        o_results    <= o_results + seen;
        o_flagged    <= o_flagged + flagged;
        o_pending    <= scaled_results_q.size();
    end

endmodule

/* test/tb_scaled_decimal_alu_core.sv */
`timescale 1ns / 100ps
// Testbench top for the scaled decimal ALU: clock, reset, word stimulus and verdict.
module tb_scaled_decimal_alu_core;

    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TEN_TO_19    = 64'd10000000000000000000;
    localparam int          RANDOM_WORDS = 1700;
    localparam int          STALL_LIMIT  = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_mode;
    logic [63:0] i_operand_a;
    logic [63:0] i_operand_b;
    logic [4:0]  i_precision_a;
    logic [4:0]  i_precision_b;
    logic        o_strobe;
    logic [63:0] o_result_value;
    logic [4:0]  o_result_precision;
    logic [2:0]  o_status;

    int fail_count;
    int pending;
    int results_seen;
    int flagged_seen;
    int mode_count [8];
    int quiet_cycles;

    scaled_decimal_alu_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_mode             (i_mode),
        .i_operand_a        (i_operand_a),
        .i_operand_b        (i_operand_b),
        .i_precision_a      (i_precision_a),
        .i_precision_b      (i_precision_b),
        .o_strobe           (o_strobe),
        .o_result_value     (o_result_value),
        .o_result_precision (o_result_precision),
        .o_status           (o_status)
    );

    sda_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_mode             (i_mode),
        .i_operand_a        (i_operand_a),
        .i_operand_b        (i_operand_b),
        .i_precision_a      (i_precision_a),
        .i_precision_b      (i_precision_b),
        .i_strobe           (o_strobe),
        .i_result_value     (o_result_value),
        .i_result_precision (o_result_precision),
        .i_status           (o_status),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_results          (results_seen),
        .o_flagged          (flagged_seen)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Watchdog: cycles with neither a word taken nor a result given
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one word and hold it until the unit takes it
    task automatic send_word(input logic [2:0]  m,
                             input logic [63:0] a,
                             input logic [63:0] b,
                             input logic [4:0]  pa,
                             input logic [4:0]  pb);
        start         <= 1'b1;
        i_mode        <= m;
        i_operand_a   <= a;
        i_operand_b   <= b;
        i_precision_a <= pa;
        i_precision_b <= pb;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        mode_count[m]++;
    endtask

    task automatic sit_idle(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stop sending until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Operand mix: edges, powers of ten, small values and random widths
    function automatic logic [63:0] pick_operand();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = ALL_ONES;
            2: begin
                v = 64'd1;
                repeat ($urandom_range(0, 19)) v = v * 64'd10;
            end
            3: v = 64'($urandom_range(0, 1000));
            default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        return v;
    endfunction

    // Mostly well-formed words, with a share of bad precisions and unused modes
    task automatic send_random_word();
        logic [2:0]  m;
        logic [63:0] a;
        logic [63:0] b;
        logic [4:0]  pa;
        logic [4:0]  pb;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 18) m = sda_pkg::MODE_ADD;
        else if (pick < 36) m = sda_pkg::MODE_SUB;
        else if (pick < 56) m = sda_pkg::MODE_MUL;
        else if (pick < 76) m = sda_pkg::MODE_DIV;
        else if (pick < 92) m = sda_pkg::MODE_CONV;
        else m = 3'($urandom_range(5, 7));
        a = pick_operand();
        b = pick_operand();
        if (m == sda_pkg::MODE_SUB && $urandom_range(0, 3) == 0)
            b = (a > 64'd50) ? a - 64'($urandom_range(0, 50)) : a;
        if ($urandom_range(0, 99) < 80) begin
            pa = 5'($urandom_range(0, 19));
            pb = (m == sda_pkg::MODE_CONV) ? 5'($urandom_range(0, 19)) : pa;
        end else begin
            pa = 5'($urandom_range(0, 31));
            pb = 5'($urandom_range(0, 31));
        end
        send_word(m, a, b, pa, pb);
    endtask

    initial begin
        start         <= 1'b0;
        i_rst_n       <= 1'b0;
        i_mode        <= sda_pkg::MODE_ADD;
        i_operand_a   <= '0;
        i_operand_b   <= '0;
        i_precision_a <= '0;
        i_precision_b <= '0;
        quiet_cycles  <= 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: add and subtract edges
        send_word(sda_pkg::MODE_ADD, ALL_ONES, 64'd0, 5'd0, 5'd0);
        send_word(sda_pkg::MODE_ADD, ALL_ONES, 64'd1, 5'd4, 5'd4);
        send_word(sda_pkg::MODE_ADD, 64'd0, 64'd0, 5'd19, 5'd19);
        send_word(sda_pkg::MODE_SUB, 64'd5, 64'd6, 5'd2, 5'd2);
        send_word(sda_pkg::MODE_SUB, ALL_ONES, ALL_ONES, 5'd7, 5'd7);
        send_word(sda_pkg::MODE_SUB, ALL_ONES, 64'd0, 5'd0, 5'd0);
        // multiply: overflow, exact top precision, zero
        send_word(sda_pkg::MODE_MUL, ALL_ONES, ALL_ONES, 5'd0, 5'd0);
        send_word(sda_pkg::MODE_MUL, ALL_ONES, ALL_ONES, 5'd19, 5'd19);
        send_word(sda_pkg::MODE_MUL, TEN_TO_19, 64'd1, 5'd19, 5'd19);
        send_word(sda_pkg::MODE_MUL, 64'd0, ALL_ONES, 5'd3, 5'd3);
        // divide: by zero, overflow, exact, truncated and mismatched precisions
        send_word(sda_pkg::MODE_DIV, ALL_ONES, 64'd0, 5'd6, 5'd6);
        send_word(sda_pkg::MODE_DIV, ALL_ONES, 64'd1, 5'd19, 5'd19);
        send_word(sda_pkg::MODE_DIV, ALL_ONES, ALL_ONES, 5'd0, 5'd0);
        send_word(sda_pkg::MODE_DIV, 64'd7, 64'd2, 5'd0, 5'd0);
        send_word(sda_pkg::MODE_DIV, 64'd7, 64'd0, 5'd2, 5'd3);
        // conversion up, down and to equal precision
        send_word(sda_pkg::MODE_CONV, 64'd1, ALL_ONES, 5'd0, 5'd19);
        send_word(sda_pkg::MODE_CONV, 64'd2, 64'd0, 5'd0, 5'd19);
        send_word(sda_pkg::MODE_CONV, ALL_ONES, 64'd0, 5'd19, 5'd0);
        send_word(sda_pkg::MODE_CONV, ALL_ONES, 64'd0, 5'd11, 5'd11);
        send_word(sda_pkg::MODE_CONV, 64'd123456, 64'd9, 5'd5, 5'd3);
        // precision errors, out-of-range result precision, unused modes
        send_word(sda_pkg::MODE_ADD, 64'd1, 64'd1, 5'd2, 5'd3);
        send_word(sda_pkg::MODE_SUB, 64'd9, 64'd1, 5'd20, 5'd20);
        send_word(sda_pkg::MODE_MUL, ALL_ONES, ALL_ONES, 5'd31, 5'd31);
        send_word(sda_pkg::MODE_CONV, 64'd42, 64'd0, 5'd3, 5'd31);
        send_word(sda_pkg::MODE_CONV, 64'd42, 64'd0, 5'd25, 5'd4);
        send_word(3'd5, ALL_ONES, ALL_ONES, 5'd31, 5'd31);
        send_word(3'd6, 64'd1, 64'd1, 5'd0, 5'd0);
        send_word(3'd7, 64'd0, 64'd0, 5'd19, 5'd19);
        drain_results();

        // Random words; gaps span every phase of the longest operations
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 400 || n == 1400)
                drain_results();
            if (!(n >= 700 && n < 1000) && $urandom_range(0, 99) < 22)
                sit_idle($urandom_range(1, 80));
            send_random_word();
        end

        // Let the last results come home, then allow the longest latency again
        drain_results();
        repeat (80) @(posedge i_clk);

        $display("Summary: %0d words, add %0d sub %0d mul %0d div %0d conv %0d other %0d",
                 mode_count[0] + mode_count[1] + mode_count[2] + mode_count[3] +
                 mode_count[4] + mode_count[5] + mode_count[6] + mode_count[7],
                 mode_count[0], mode_count[1], mode_count[2], mode_count[3],
                 mode_count[4], mode_count[5] + mode_count[6] + mode_count[7]);
        $display("Summary: %0d results compared, %0d carried an error status, %0d failures",
                 results_seen, flagged_seen, fail_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/sda_pkg.sv
sv/sda_mul.sv
sv/sda_div.sv
sv/scaled_decimal_alu_core.sv
test/sda_checker.sv
test/tb_scaled_decimal_alu_core.sv
